// ===== rtl/core/fcp_pkg.sv =====
package fcp_pkg;

  localparam int unsigned PosW      = 12;
  localparam int unsigned LenW      = 9;
  localparam int unsigned NameStart = 45;
  localparam int unsigned LenLast   = 44;
  localparam int unsigned NameMax   = 256;
  localparam int unsigned TailBytes = 17;
  localparam int unsigned CountOff  = 16;
  localparam int unsigned FrameOff  = 3;
  localparam int unsigned SubOff    = 7;
  localparam int unsigned FpsOff    = 11;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_FRAME  = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_FPS    = 3'd3,
    KIND_VALUE  = 3'd4,
    KIND_STATUS = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NAME_LONG = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  item_index;
    logic [31:0] word;
    status_e     status;
    logic        last_of_packet;
  } result_t;

endpackage

// ===== rtl/core/fcp_in_if.sv =====
interface fcp_in_if;
  import fcp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_packet;

  modport source (output valid, output in_byte, output end_of_packet, input ready);
  modport sink (input valid, input in_byte, input end_of_packet, output ready);

endinterface

// ===== rtl/core/fcp_out_if.sv =====
interface fcp_out_if;
  import fcp_pkg::*;

  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  item_index;
  logic [31:0] word;
  status_e     status;
  logic        last_of_packet;

  modport source (
    output valid, output kind, output item_index, output word, output status,
    output last_of_packet, input ready
  );
  modport sink (
    input valid, input kind, input item_index, input word, input status,
    input last_of_packet, output ready
  );

endinterface

// ===== rtl/core/face_capture_packet_parser.sv =====
// a result is written into the result queue when the byte that causes it is taken
// throughput: one byte per cycle while the queue has room; a byte may yield up to two items (word and status)
// results leave through a four-entry queue; bytes are taken while two entries are free
// reset (rst_ni low, asynchronous) clears the byte counter, error state and the queue
// a status item clears the parser state for the next packet
module face_capture_packet_parser #(
  parameter int unsigned VALUE_COUNT      = 61,
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fcp_in_if.sink        in_i,
  fcp_out_if.source     out_o
);
  import fcp_pkg::*;

  localparam int unsigned ValueBytes = 4 * VALUE_COUNT;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     asm_q, asm_d;
  logic [LenW-1:0] len_q, len_d;
  status_e         err_q, err_d;

  result_t            q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  logic            accept;
  logic            pop;
  logic            pos_ok;
  logic [31:0]     asm_new;
  logic [PosW-1:0] rel;
  logic [PosW-1:0] r;
  logic [PosW-1:0] rv;
  logic [PosW-1:0] n;
  logic [PosW-1:0] req_len;
  logic            data_v;
  result_t         data_res;
  result_t         stat_res;
  result_t         slot0, slot1;
  logic [1:0]      push_n;

  assign in_i.ready = (cnt_q <= QCntW'(QDepth - 2));
  assign accept     = in_i.valid && in_i.ready;

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.kind           = q_mem[rd_ptr_q].kind;
  assign out_o.item_index     = q_mem[rd_ptr_q].item_index;
  assign out_o.word           = q_mem[rd_ptr_q].word;
  assign out_o.status         = q_mem[rd_ptr_q].status;
  assign out_o.last_of_packet = q_mem[rd_ptr_q].last_of_packet;
  assign pop = out_o.valid && out_o.ready;

  assign pos_ok  = (pos_q < PosW'(MAX_PACKET_BYTES));
  assign asm_new = {asm_q[23:0], in_i.in_byte};
  assign rel     = pos_q - PosW'(NameStart);
  assign r       = rel - PosW'(len_q);
  assign rv      = r - PosW'(TailBytes);
  assign n       = pos_ok ? pos_q + PosW'(1) : pos_q;
  assign req_len = PosW'(NameStart) + PosW'(len_q) + PosW'(TailBytes) + PosW'(ValueBytes);

  always_comb begin
    pos_d    = pos_q;
    asm_d    = asm_q;
    len_d    = len_q;
    err_d    = err_q;
    data_v   = 1'b0;
    data_res = '{kind: KIND_NAME, item_index: '0, word: asm_new, status: ST_OK,
                 last_of_packet: 1'b0};
    stat_res = '{kind: KIND_STATUS, item_index: '0, word: '0, status: ST_OK,
                 last_of_packet: 1'b1};
    if (pos_ok) begin
      asm_d = asm_new;
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosW'(LenLast)) begin
        if (asm_new > 32'(NameMax)) begin
          err_d = ST_NAME_LONG;
          len_d = '0;
        end else begin
          len_d = asm_new[LenW-1:0];
        end
      end else if (pos_q >= PosW'(NameStart) && err_q == ST_OK) begin
        if (rel < PosW'(len_q)) begin
          data_v              = 1'b1;
          data_res.kind       = KIND_NAME;
          data_res.item_index = rel[7:0];
          data_res.word       = {24'd0, in_i.in_byte};
        end else if (r == PosW'(FrameOff)) begin
          data_v        = 1'b1;
          data_res.kind = KIND_FRAME;
        end else if (r == PosW'(SubOff)) begin
          data_v        = 1'b1;
          data_res.kind = KIND_SUB;
        end else if (r == PosW'(FpsOff)) begin
          data_v        = 1'b1;
          data_res.kind = KIND_FPS;
        end else if (r == PosW'(CountOff)) begin
          if (in_i.in_byte != 8'(VALUE_COUNT)) begin
            err_d = ST_MISMATCH;
          end
        end else if (r >= PosW'(TailBytes) && r < PosW'(TailBytes + ValueBytes) &&
                     rv[1:0] == 2'd3) begin
          data_v              = 1'b1;
          data_res.kind       = KIND_VALUE;
          data_res.item_index = rv[9:2];
        end
      end
    end
    if (n < PosW'(NameStart)) begin
      stat_res.status = ST_SHORT;
    end else if (err_d == ST_NAME_LONG) begin
      stat_res.status = ST_NAME_LONG;
    end else if (n < req_len) begin
      stat_res.status = ST_TRUNC;
    end else if (err_d == ST_MISMATCH) begin
      stat_res.status = ST_MISMATCH;
    end else begin
      stat_res.status = ST_OK;
    end
    if (in_i.end_of_packet) begin
      pos_d = '0;
      asm_d = '0;
      len_d = '0;
      err_d = ST_OK;
    end
  end

  always_comb begin
    slot0  = data_v ? data_res : stat_res;
    slot1  = stat_res;
    push_n = 2'd0;
    if (accept) begin
      push_n = 2'(data_v) + 2'(in_i.end_of_packet);
    end
    cnt_d = cnt_q + QCntW'(push_n) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      asm_q    <= '0;
      len_q    <= '0;
      err_q    <= ST_OK;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
        asm_q <= asm_d;
        len_q <= len_d;
        err_q <= err_d;
      end
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_q] <= slot0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_q + QPtrW'(1)] <= slot1;
    end
  end

endmodule

// ===== verif/tb_face_capture_packet_parser.sv =====
`timescale 1ns / 1ps

module tb_face_capture_packet_parser;
  import fcp_pkg::*;

  localparam int unsigned ValueCount  = 61;
  localparam int unsigned MaxBytes    = 2048;
  localparam int unsigned LenFirst    = 41;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PhaseBytes  = 120;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND} fill_e;
  typedef enum int {PH_IDLE_A, PH_IDLE_B, PH_STEADY} phase_e;

  typedef struct {
    int          len;
    logic [31:0] name_len;
    logic [7:0]  count;
    fill_e       fill;
    bit          typed;
    status_e     st;
  } packet_row_t;

  logic clk_i;
  logic rst_ni;

  fcp_in_if  byte_ch ();
  fcp_out_if result_ch ();

  face_capture_packet_parser #(
    .VALUE_COUNT      (ValueCount),
    .MAX_PACKET_BYTES (MaxBytes)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (result_ch)
  );

  // parser state mirror
  logic [PosW-1:0] p_pos;
  logic [31:0]     p_shift;
  logic [LenW-1:0] p_name_len;
  status_e         p_err;

  result_t pending_results[$];
  int      mismatches;
  phase_e  phase;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_left;
  bit      held_once;
  int      quiet_cycles;

  packet_row_t directed_rows [10] = '{
    '{1,    32'd0,         ValueCount[7:0], FILL_ZERO, 1'b1, ST_SHORT},
    '{44,   32'd0,         ValueCount[7:0], FILL_ONES, 1'b1, ST_SHORT},
    '{45,   32'd0,         ValueCount[7:0], FILL_ZERO, 1'b1, ST_TRUNC},
    '{306,  32'd0,         ValueCount[7:0], FILL_ZERO, 1'b1, ST_OK},
    '{50,   32'd256,       ValueCount[7:0], FILL_ONES, 1'b1, ST_TRUNC},
    '{100,  32'd257,       ValueCount[7:0], FILL_RAND, 1'b1, ST_NAME_LONG},
    '{60,   32'hFFFF_FFFF, ValueCount[7:0], FILL_ONES, 1'b1, ST_NAME_LONG},
    '{306,  32'd0,         8'd0,            FILL_ZERO, 1'b1, ST_MISMATCH},
    '{70,   32'd0,         8'd7,            FILL_RAND, 1'b1, ST_TRUNC},
    '{80,   32'd20,        ValueCount[7:0], FILL_RAND, 1'b0, ST_OK}
  };

  function automatic void add_result(kind_e kind, logic [7:0] idx, logic [31:0] word,
                                     status_e st, logic last);
    result_t r;
    r.kind           = kind;
    r.item_index     = idx;
    r.word           = word;
    r.status         = st;
    r.last_of_packet = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void clear_parser();
    p_pos      = '0;
    p_shift    = '0;
    p_name_len = '0;
    p_err      = ST_OK;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eop);
    int unsigned rel;
    int unsigned tail;
    int unsigned n;
    status_e     st;
    if (p_pos < MaxBytes) begin
      p_shift = {p_shift[23:0], b};
      if (p_pos == LenLast) begin
        if (p_shift > NameMax) begin
          p_err      = ST_NAME_LONG;
          p_name_len = '0;
        end else begin
          p_name_len = p_shift[LenW-1:0];
        end
      end else if (p_pos >= NameStart && p_err == ST_OK) begin
        rel = p_pos - NameStart;
        if (rel < p_name_len) begin
          add_result(KIND_NAME, rel[7:0], {24'd0, b}, ST_OK, 1'b0);
        end else begin
          tail = rel - p_name_len;
          if (tail == FrameOff) begin
            add_result(KIND_FRAME, 8'd0, p_shift, ST_OK, 1'b0);
          end else if (tail == SubOff) begin
            add_result(KIND_SUB, 8'd0, p_shift, ST_OK, 1'b0);
          end else if (tail == FpsOff) begin
            add_result(KIND_FPS, 8'd0, p_shift, ST_OK, 1'b0);
          end else if (tail == CountOff) begin
            if (b != ValueCount[7:0]) p_err = ST_MISMATCH;
          end else if (tail >= TailBytes && tail < TailBytes + 4 * ValueCount &&
                       ((tail - TailBytes) % 4) == 3) begin
            add_result(KIND_VALUE, 8'((tail - TailBytes) >> 2), p_shift, ST_OK, 1'b0);
          end
        end
      end
      p_pos = p_pos + 1'b1;
    end
    if (eop) begin
      n = p_pos;
      if (n < NameStart) st = ST_SHORT;
      else if (p_err == ST_NAME_LONG) st = ST_NAME_LONG;
      else if (n < NameStart + p_name_len + TailBytes + 4 * ValueCount) st = ST_TRUNC;
      else if (p_err == ST_MISMATCH) st = ST_MISMATCH;
      else st = ST_OK;
      add_result(KIND_STATUS, 8'd0, 32'd0, st, 1'b1);
      clear_parser();
    end
  endfunction

  task automatic set_phase(phase_e ph);
    phase = ph;
    case (ph)
      PH_IDLE_A: begin
        send_idle_pct = 20;
        recv_idle_pct = 47;
      end
      PH_IDLE_B: begin
        send_idle_pct = 47;
        recv_idle_pct = 20;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] b, logic eop);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.in_byte       <= b;
    byte_ch.end_of_packet <= eop;
    do @(posedge clk_i); while (!byte_ch.ready);
    parse_byte(b, eop);
  endtask

  task automatic send_packet(int len, logic [31:0] name_len, logic [7:0] count, fill_e fill,
                             bit typed, status_e st);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i >= LenFirst && i <= LenLast) begin
        b = name_len[8 * (LenLast - i) +: 8];
      end else if (name_len <= NameMax && i == NameStart + name_len + CountOff) begin
        b = count;
      end else begin
        case (fill)
          FILL_ZERO: b = 8'h00;
          FILL_ONES: b = 8'hFF;
          default:   b = 8'($urandom_range(0, 255));
        endcase
      end
      send_byte(b, i == len - 1);
    end
    if (typed) pending_results[$].status = st;
  endtask

  task automatic random_packets(int budget);
    int          sent;
    int          sel;
    int          len;
    int          need;
    logic [31:0] name_len;
    logic [7:0]  count;
    sent = 0;
    while (sent < budget) begin
      sel      = $urandom_range(0, 9);
      name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NameMax) : $urandom_range(0, 8);
      need     = NameStart + name_len + TailBytes + 4 * ValueCount;
      count    = ValueCount[7:0];
      len      = need + $urandom_range(0, 3);
      case (sel)
        6: len = $urandom_range(NameStart, need - 1);
        7: len = $urandom_range(1, NameStart - 1);
        8: begin
          count = 8'($urandom_range(0, 255));
          if (count == ValueCount[7:0]) count = count + 8'd1;
        end
        9: begin
          name_len = $urandom;
          if (name_len <= NameMax) name_len = name_len + NameMax + 1;
          len = $urandom_range(NameStart, 120);
        end
        default: ;
      endcase
      send_packet(len, name_len, count, FILL_RAND, 1'b0, ST_OK);
      sent += len;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == PH_STEADY && !held_once) begin
      // long back-pressure so the result queue fills and input stalls
      held_once <= 1'b1;
      hold_left <= HoldCycles;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected nothing, got kind=%0d idx=%0d word=%h status=%0d last=%0b",
                 $time, result_ch.kind, result_ch.item_index, result_ch.word,
                 result_ch.status, result_ch.last_of_packet);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.kind !== want.kind || result_ch.item_index !== want.item_index ||
            result_ch.word !== want.word || result_ch.status !== want.status ||
            result_ch.last_of_packet !== want.last_of_packet) begin
          mismatches++;
          $display("%0t: expected kind=%0d idx=%0d word=%h status=%0d last=%0b", $time,
                   want.kind, want.item_index, want.word, want.status, want.last_of_packet);
          $display("%0t: actual   kind=%0d idx=%0d word=%h status=%0d last=%0b", $time,
                   result_ch.kind, result_ch.item_index, result_ch.word, result_ch.status,
                   result_ch.last_of_packet);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    byte_ch.valid         = 1'b0;
    byte_ch.in_byte       = 8'h00;
    byte_ch.end_of_packet = 1'b0;
    result_ch.ready       = 1'b0;
    mismatches            = 0;
    hold_left             = 0;
    held_once             = 1'b0;
    quiet_cycles          = 0;
    set_phase(PH_IDLE_A);
    clear_parser();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_packet(directed_rows[i].len, directed_rows[i].name_len, directed_rows[i].count,
                  directed_rows[i].fill, directed_rows[i].typed, directed_rows[i].st);
    end
    random_packets(PhaseBytes);
    set_phase(PH_IDLE_B);
    random_packets(PhaseBytes);
    set_phase(PH_STEADY);
    random_packets(PhaseBytes);

    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
